// ===== src/zse_pkg.sv =====
// ----------------------------------------------------------------------------
// zse_pkg
// Shared types and constants for the ZIP stored entry extractor.
// ----------------------------------------------------------------------------
package zse_pkg;

    // Archive format constants
    localparam logic [31:0] LFH_MAGIC      = 32'h04034b50;
    localparam logic [15:0] UTF8_FLAG      = 16'h0800;
    localparam int          LFH_BYTES      = 30;
    localparam int          MAX_NAME_BYTES = 32;
    localparam int          NAME_BITS      = 256;

    // Configuration register indexes
    localparam logic [2:0] CFG_NAME_LEN   = 3'd0;
    localparam logic [2:0] CFG_NAME_WORD0 = 3'd1;
    localparam logic [2:0] CFG_NAME_WORD1 = 3'd2;
    localparam logic [2:0] CFG_NAME_WORD2 = 3'd3;
    localparam logic [2:0] CFG_NAME_WORD3 = 3'd4;

    // Parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_EXTRA   = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FLAGS      = 3'd1;
    localparam logic [2:0] ST_COMPRESSED = 3'd2;
    localparam logic [2:0] ST_SIZE       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [5:0]           name_len;
        logic [NAME_BITS-1:0] name;
    } t_cfg;

    // Results produced by one accepted item: optional payload, then optional status
    typedef struct packed {
        logic       have_pay;
        logic       have_stat;
        logic [7:0] pay_byte;
        logic [2:0] stat_code;
    } t_push;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [2:0] status_code;
        logic       last_result;
    } t_result;

endpackage

// ===== src/zip_stored_entry_extractor_top.sv =====
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor_top
// Streams a ZIP archive byte by byte and extracts one stored entry by name.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   archive_byte, end_of_archive
//  out       output     o_out_valid / i_out_stall is_status, payload_byte,
//                                                 status_code, last_result
//  cfg       input      i_cfg_valid / o_cfg_ready index (3b), data (64b)
//
// One archive byte is taken per cycle unless the input is stalled; its results
// enter a four-entry result queue in the same cycle and can leave on the next.
// The last payload byte of the extracted entry gives two results, payload then
// status, delivered one after the other. The input stalls while fewer than two
// queue entries are free. Reset is synchronous; no clearing pass follows.
// Configuration writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module zip_stored_entry_extractor_top
    import zse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // archive byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_archive_byte,
    input  logic        i_end_of_archive,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_status,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status_code,
    output logic        o_last_result,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_push   push;
    t_result head;
    logic    nearly_full;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = nearly_full;
    assign accept      = i_in_valid && !nearly_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NAME_LEN:   r_cfg.name_len      <= i_cfg_data[5:0];
                CFG_NAME_WORD0: r_cfg.name[63:0]    <= i_cfg_data;
                CFG_NAME_WORD1: r_cfg.name[127:64]  <= i_cfg_data;
                CFG_NAME_WORD2: r_cfg.name[191:128] <= i_cfg_data;
                CFG_NAME_WORD3: r_cfg.name[255:192] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    zse_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (accept),
        .i_archive_byte   (i_archive_byte),
        .i_end_of_archive (i_end_of_archive),
        .o_push           (push)
    );

    zse_out_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_nearly_full (nearly_full),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_head        (head)
    );

    assign o_is_status    = head.is_status;
    assign o_payload_byte = head.payload_byte;
    assign o_status_code  = head.status_code;
    assign o_last_result  = head.last_result;

endmodule

// ===== src/zse_parser.sv =====
// ----------------------------------------------------------------------------
// zse_parser
// Local file header walker: per-byte parse state and result generation.
// ----------------------------------------------------------------------------
module zse_parser
    import zse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_archive_byte,
    input  logic       i_end_of_archive,
    output t_push      o_push
);

    logic [2:0]  r_phase,     n_phase;
    logic [4:0]  r_fbc,       n_fbc;
    logic [31:0] r_sig,       n_sig;
    logic [15:0] r_flags,     n_flags;
    logic [15:0] r_method,    n_method;
    logic [31:0] r_packed,    n_packed;
    logic [31:0] r_unpacked,  n_unpacked;
    logic [15:0] r_name_len,  n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [15:0] r_name_pos,  n_name_pos;
    logic        r_eq,        n_eq;
    logic [31:0] r_skip,      n_skip;
    logic [2:0]  r_perr,      n_perr;
    logic        r_sent,      n_sent;

    logic        go_name, go_extra, go_data, go_finish;
    logic        put_stat;
    logic [2:0]  stat_code;
    logic        put_pay;
    logic [4:0]  off_packed, off_unpacked;
    logic [7:0]  tgt_byte;

    assign off_packed   = r_fbc - 5'd18;
    assign off_unpacked = r_fbc - 5'd22;
    assign tgt_byte     = i_cfg.name[{r_name_pos[4:0], 3'b000} +: 8];

    // Next-state and result logic for one byte
    always_comb begin
        n_phase     = r_phase;
        n_fbc       = r_fbc;
        n_sig       = r_sig;
        n_flags     = r_flags;
        n_method    = r_method;
        n_packed    = r_packed;
        n_unpacked  = r_unpacked;
        n_name_len  = r_name_len;
        n_extra_len = r_extra_len;
        n_name_pos  = r_name_pos;
        n_eq        = r_eq;
        n_skip      = r_skip;
        n_perr      = r_perr;
        n_sent      = r_sent;
        go_name     = 1'b0;
        go_extra    = 1'b0;
        go_data     = 1'b0;
        go_finish   = 1'b0;
        put_stat    = 1'b0;
        stat_code   = ST_OK;
        put_pay     = 1'b0;

        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_fbc == 5'd0) begin
                        n_sig       = '0;
                        n_flags     = '0;
                        n_method    = '0;
                        n_packed    = '0;
                        n_unpacked  = '0;
                        n_name_len  = '0;
                        n_extra_len = '0;
                    end
                    // place the byte into its header field
                    if (r_fbc < 5'd4) begin
                        n_sig[{r_fbc[1:0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc == 5'd6 || r_fbc == 5'd7) begin
                        n_flags[{r_fbc[0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc == 5'd8 || r_fbc == 5'd9) begin
                        n_method[{r_fbc[0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc >= 5'd18 && r_fbc <= 5'd21) begin
                        n_packed[{off_packed[1:0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc >= 5'd22 && r_fbc <= 5'd25) begin
                        n_unpacked[{off_unpacked[1:0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc == 5'd26 || r_fbc == 5'd27) begin
                        n_name_len[{r_fbc[0], 3'b000} +: 8] = i_archive_byte;
                    end else if (r_fbc == 5'd28 || r_fbc == 5'd29) begin
                        n_extra_len[{r_fbc[0], 3'b000} +: 8] = i_archive_byte;
                    end
                    if (r_fbc == 5'(LFH_BYTES - 1)) begin
                        n_fbc = '0;
                        if (n_sig != LFH_MAGIC) begin
                            put_stat  = 1'b1;
                            stat_code = ST_NOT_FOUND;
                        end else begin
                            go_name = 1'b1;
                        end
                    end else begin
                        n_fbc = r_fbc + 5'd1;
                    end
                end
                PH_NAME: begin
                    if (r_eq && (i_archive_byte != tgt_byte)) begin
                        n_eq = 1'b0;
                    end
                    n_name_pos = r_name_pos + 16'd1;
                    if (n_name_pos == r_name_len) begin
                        go_extra = 1'b1;
                    end
                end
                PH_EXTRA: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        go_data = 1'b1;
                    end
                end
                PH_SKIP, PH_PAYLOAD: begin
                    put_pay = (r_phase == PH_PAYLOAD);
                    n_skip  = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        go_finish = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // entry name starts
            if (go_name) begin
                n_phase    = PH_NAME;
                n_name_pos = '0;
                n_eq       = (n_name_len == {10'b0, i_cfg.name_len}) &&
                             (i_cfg.name_len <= 6'(MAX_NAME_BYTES));
                if (n_name_len == 16'd0) begin
                    go_extra = 1'b1;
                end
            end
            // extra field starts
            if (go_extra) begin
                n_phase = PH_EXTRA;
                n_skip  = {16'b0, n_extra_len};
                if (n_extra_len == 16'd0) begin
                    go_data = 1'b1;
                end
            end
            // entry data starts: checks on the matching entry
            if (go_data) begin
                n_perr  = ST_OK;
                n_phase = PH_SKIP;
                if (n_eq) begin
                    if ((n_flags & ~UTF8_FLAG) != 16'd0) begin
                        n_perr = ST_FLAGS;
                    end else if (n_method != 16'd0) begin
                        n_perr = ST_COMPRESSED;
                    end else if (n_packed != n_unpacked) begin
                        n_perr = ST_SIZE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                n_skip = n_packed;
                if (n_packed == 32'd0) begin
                    go_finish = 1'b1;
                end
            end
            // entry data done
            if (go_finish) begin
                if (n_phase == PH_PAYLOAD) begin
                    put_stat  = 1'b1;
                    stat_code = ST_OK;
                end else if (n_perr != ST_OK) begin
                    put_stat  = 1'b1;
                    stat_code = n_perr;
                end else begin
                    n_phase = PH_HEADER;
                    n_fbc   = '0;
                end
            end
            if (put_stat) begin
                n_sent  = 1'b1;
                n_phase = PH_DONE;
            end

            // end of archive: report not found if nothing was reported, then clear
            if (i_end_of_archive) begin
                if (!n_sent) begin
                    put_stat  = 1'b1;
                    stat_code = ST_NOT_FOUND;
                end
                n_phase     = PH_HEADER;
                n_fbc       = '0;
                n_sig       = '0;
                n_flags     = '0;
                n_method    = '0;
                n_packed    = '0;
                n_unpacked  = '0;
                n_name_len  = '0;
                n_extra_len = '0;
                n_name_pos  = '0;
                n_eq        = 1'b1;
                n_skip      = '0;
                n_perr      = ST_OK;
                n_sent      = 1'b0;
            end
        end
    end

    always_comb begin
        o_push.have_pay  = put_pay;
        o_push.have_stat = put_stat;
        o_push.pay_byte  = i_archive_byte;
        o_push.stat_code = stat_code;
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_fbc       <= '0;
            r_sig       <= '0;
            r_flags     <= '0;
            r_method    <= '0;
            r_packed    <= '0;
            r_unpacked  <= '0;
            r_name_len  <= '0;
            r_extra_len <= '0;
            r_name_pos  <= '0;
            r_eq        <= 1'b1;
            r_skip      <= '0;
            r_perr      <= ST_OK;
            r_sent      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_fbc       <= n_fbc;
            r_sig       <= n_sig;
            r_flags     <= n_flags;
            r_method    <= n_method;
            r_packed    <= n_packed;
            r_unpacked  <= n_unpacked;
            r_name_len  <= n_name_len;
            r_extra_len <= n_extra_len;
            r_name_pos  <= n_name_pos;
            r_eq        <= n_eq;
            r_skip      <= n_skip;
            r_perr      <= n_perr;
            r_sent      <= n_sent;
        end
    end

endmodule

// ===== src/zse_out_queue.sv =====
// ----------------------------------------------------------------------------
// zse_out_queue
// Small result queue: takes up to two results per cycle, delivers one when not stalled.
// ----------------------------------------------------------------------------
module zse_out_queue
    import zse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_nearly_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_head
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 pop;
    logic [1:0]           n_push;
    t_result              slot0, slot1;
    logic [Q_PTR_W-1:0]   wr_ptr1;

    assign o_valid       = (r_count != '0);
    assign o_nearly_full = (r_count > Q_CNT_W'(Q_DEPTH - 2));
    assign pop           = o_valid && !i_stall;
    assign o_head        = r_mem[r_rd_ptr];
    assign wr_ptr1       = r_wr_ptr + 1'b1;

    // Build the entries: payload first, status after it
    always_comb begin
        slot1.is_status    = 1'b1;
        slot1.payload_byte = 8'd0;
        slot1.status_code  = i_push.stat_code;
        slot1.last_result  = 1'b1;
        if (i_push.have_pay) begin
            slot0.is_status    = 1'b0;
            slot0.payload_byte = i_push.pay_byte;
            slot0.status_code  = ST_OK;
            slot0.last_result  = 1'b0;
        end else begin
            slot0 = slot1;
        end
        n_push   = {1'b0, i_push.have_pay} + {1'b0, i_push.have_stat};
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(n_push);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_mem[r_wr_ptr] <= slot0;
        end
        if (n_push == 2'd2) begin
            r_mem[wr_ptr1] <= slot1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== test/zse_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_result_checker
// Watches the archive, configuration and result channels of the extractor.
// Keeps its own parser state, predicts the payload bytes and the status item
// each accepted archive byte should produce, and compares every result.
// ----------------------------------------------------------------------------
module zse_result_checker
    import zse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // archive byte channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_archive_byte,
    input  logic        i_end_of_archive,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_status,
    input  logic [7:0]  i_payload_byte,
    input  logic [2:0]  i_status_code,
    input  logic        i_last_result,
    // configuration write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // summary for the testbench top
    output int          o_fail_count,
    output int          o_due_count,
    output int          o_checked_count
);

    // Target name copy
    logic [5:0]   tgt_len;
    logic [255:0] tgt_name;

    // Parser state
    logic [2:0]  phase;
    logic [4:0]  hdr_cnt;
    logic [31:0] sig;
    logic [15:0] flags;
    logic [15:0] method;
    logic [31:0] csize;
    logic [31:0] usize;
    logic [15:0] nlen;
    logic [15:0] xlen;
    logic [15:0] npos;
    logic        neq;
    logic [31:0] remain;
    logic [2:0]  perr;
    logic        sent;

    // Results still owed by the block, oldest first
    t_result due_q[$];
    t_result want;
    int      fails;
    int      checked;

    task automatic restart_archive();
        phase   = PH_HEADER;
        hdr_cnt = '0;
        sig     = '0;
        flags   = '0;
        method  = '0;
        csize   = '0;
        usize   = '0;
        nlen    = '0;
        xlen    = '0;
        npos    = '0;
        neq     = 1'b1;
        remain  = '0;
        perr    = ST_OK;
        sent    = 1'b0;
    endtask

    task automatic owe_payload(input logic [7:0] b);
        t_result r;
        r.is_status    = 1'b0;
        r.payload_byte = b;
        r.status_code  = ST_OK;
        r.last_result  = 1'b0;
        due_q.push_back(r);
    endtask

    // The status item closes the archive; later bytes are ignored
    task automatic owe_status(input logic [2:0] code);
        t_result r;
        r.is_status    = 1'b1;
        r.payload_byte = '0;
        r.status_code  = code;
        r.last_result  = 1'b1;
        due_q.push_back(r);
        sent  = 1'b1;
        phase = PH_DONE;
    endtask

    // Data of the entry fully consumed
    task automatic close_entry();
        if (phase == PH_PAYLOAD) begin
            owe_status(ST_OK);
        end else if (perr != ST_OK) begin
            owe_status(perr);
        end else begin
            phase   = PH_HEADER;
            hdr_cnt = '0;
        end
    endtask

    // Matching entry: flags, then method, then size; error waits out the data
    task automatic open_data();
        perr  = ST_OK;
        phase = PH_SKIP;
        if (neq) begin
            if ((flags & ~UTF8_FLAG) != 16'd0)
                perr = ST_FLAGS;
            else if (method != 16'd0)
                perr = ST_COMPRESSED;
            else if (csize != usize)
                perr = ST_SIZE;
            else
                phase = PH_PAYLOAD;
        end
        remain = csize;
        if (remain == 32'd0)
            close_entry();
    endtask

    task automatic open_extra();
        phase  = PH_EXTRA;
        remain = {16'd0, xlen};
        if (remain == 32'd0)
            open_data();
    endtask

    // Oversized target length can never match
    task automatic open_name();
        phase = PH_NAME;
        npos  = '0;
        neq   = (nlen == {10'd0, tgt_len}) && (tgt_len <= MAX_NAME_BYTES);
        if (nlen == 16'd0)
            open_extra();
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eoa);
        int pos;
        case (phase)
            PH_HEADER: begin
                pos = hdr_cnt;
                if (pos == 0) begin
                    sig    = '0;
                    flags  = '0;
                    method = '0;
                    csize  = '0;
                    usize  = '0;
                    nlen   = '0;
                    xlen   = '0;
                end
                // little-endian header fields
                if (pos < 4)
                    sig[8*pos +: 8] = b;
                else if (pos == 6 || pos == 7)
                    flags[8*(pos-6) +: 8] = b;
                else if (pos == 8 || pos == 9)
                    method[8*(pos-8) +: 8] = b;
                else if (pos >= 18 && pos <= 21)
                    csize[8*(pos-18) +: 8] = b;
                else if (pos >= 22 && pos <= 25)
                    usize[8*(pos-22) +: 8] = b;
                else if (pos == 26 || pos == 27)
                    nlen[8*(pos-26) +: 8] = b;
                else if (pos == 28 || pos == 29)
                    xlen[8*(pos-28) +: 8] = b;
                pos++;
                if (pos >= LFH_BYTES) begin
                    hdr_cnt = '0;
                    if (sig != LFH_MAGIC)
                        owe_status(ST_NOT_FOUND);
                    else
                        open_name();
                end else begin
                    hdr_cnt = 5'(pos);
                end
            end
            PH_NAME: begin
                if (neq && b != tgt_name[8*npos[4:0] +: 8])
                    neq = 1'b0;
                npos = npos + 16'd1;
                if (npos == nlen)
                    open_extra();
            end
            PH_EXTRA: begin
                remain = remain - 32'd1;
                if (remain == 32'd0)
                    open_data();
            end
            PH_SKIP, PH_PAYLOAD: begin
                if (phase == PH_PAYLOAD)
                    owe_payload(b);
                remain = remain - 32'd1;
                if (remain == 32'd0)
                    close_entry();
            end
            default: ;
        endcase

        // end marker: not found unless a status already went out
        if (eoa) begin
            if (!sent)
                owe_status(ST_NOT_FOUND);
            restart_archive();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tgt_len  = '0;
            tgt_name = '0;
            restart_archive();
            due_q.delete();
            fails    = 0;
            checked  = 0;
        end else begin
            // compare the result leaving the block
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (due_q.size() == 0) begin
                    $error("unexpected result: is_status %0d payload_byte 0x%02h status_code %0d",
                           i_is_status, i_payload_byte, i_status_code);
                    fails++;
                end else begin
                    want = due_q.pop_front();
                    if (i_is_status !== want.is_status) begin
                        $error("is_status: expected %0d, actual %0d",
                               want.is_status, i_is_status);
                        fails++;
                    end
                    if (i_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected 0x%02h, actual 0x%02h",
                               want.payload_byte, i_payload_byte);
                        fails++;
                    end
                    if (i_status_code !== want.status_code) begin
                        $error("status_code: expected %0d, actual %0d",
                               want.status_code, i_status_code);
                        fails++;
                    end
                    if (i_last_result !== want.last_result) begin
                        $error("last_result: expected %0d, actual %0d",
                               want.last_result, i_last_result);
                        fails++;
                    end
                end
            end

            // register writes; unknown indexes do nothing
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NAME_LEN:   tgt_len = i_cfg_data[5:0];
                    CFG_NAME_WORD0: tgt_name[63:0] = i_cfg_data;
                    CFG_NAME_WORD1: tgt_name[127:64] = i_cfg_data;
                    CFG_NAME_WORD2: tgt_name[191:128] = i_cfg_data;
                    CFG_NAME_WORD3: tgt_name[255:192] = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                parse_byte(i_archive_byte, i_end_of_archive);
        end

        o_fail_count    <= fails;
        o_due_count     <= due_q.size();
        o_checked_count <= checked;
    end

endmodule

// ===== test/zip_stored_entry_extractor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor_top_tb
// Builds ZIP archives byte by byte (hits, misses, rejected entries, bad
// signatures, truncations and noise), streams them with random gaps and
// result stalls across several target names, and leaves all checking to
// zse_result_checker.
// ----------------------------------------------------------------------------
module zip_stored_entry_extractor_top_tb;
    import zse_pkg::*;

    // total archive bytes for the whole run; the random phase tops up the
    // directed cases to this budget, with a few random archives at least
    localparam int          ITEM_TARGET         = 450;
    localparam int          MIN_RANDOM_ARCHIVES = 3;
    localparam int          BODY_CAP            = 64;
    localparam int          SETTLE_CYCLES       = 4;
    localparam int          TAIL_CYCLES         = 10;
    // worst legal quiet stretch is a full random input gap or output stall plus
    // the settling wait; this is far above it
    localparam int          QUIET_LIMIT         = 400;
    localparam logic [15:0] METHOD_STORED       = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE      = 16'd8;
    localparam logic [15:0] FLAG_ENCRYPTED      = 16'h0001;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_archive_byte;
    logic        i_end_of_archive;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_is_status;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status_code;
    logic        o_last_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int fail_count;
    int due_count;
    int checked_count;

    // archive under construction and the current target
    logic [7:0]   arc[$];
    logic [255:0] tgt;
    int           tgt_n;

    bit tx_busy;
    bit rx_busy;
    int bytes_sent;
    int archives_sent;
    int cfg_writes;
    int quiet_cycles;
    int rx_hold;
    int rx_draw;

    zip_stored_entry_extractor_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_archive_byte   (i_archive_byte),
        .i_end_of_archive (i_end_of_archive),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_status      (o_is_status),
        .o_payload_byte   (o_payload_byte),
        .o_status_code    (o_status_code),
        .o_last_result    (o_last_result),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    zse_result_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_archive_byte   (i_archive_byte),
        .i_end_of_archive (i_end_of_archive),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_is_status      (o_is_status),
        .i_payload_byte   (o_payload_byte),
        .i_status_code    (o_status_code),
        .i_last_result    (o_last_result),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_due_count      (due_count),
        .o_checked_count  (checked_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: after each accepted item, may stall before taking the next while rx_busy is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold     <= 0;
            i_out_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_stall <= (rx_hold > 1);
        end else if (o_out_valid && !i_out_stall) begin
            rx_draw = rx_busy ? $urandom_range(0, 9) : 0;
            rx_hold     <= rx_draw;
            i_out_stall <= (rx_draw > 0);
        end
    end

    // Watchdog: any handshake resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results still due",
                     QUIET_LIMIT, due_count);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [255:0] rand_name();
        logic [255:0] nm;
        for (int i = 0; i < 8; i++)
            nm[32*i +: 32] = $urandom();
        return nm;
    endfunction

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            arc.push_back(v[8*i +: 8]);
    endtask

    task automatic put_tail(input int n);
        repeat (n) arc.push_back(8'($urandom()));
    endtask

    // One local header with its name, extra field and data
    task automatic put_entry(input logic [31:0] sig, input logic [15:0] fl,
                             input logic [15:0] md, input logic [31:0] cs,
                             input logic [31:0] us, input logic [15:0] nlen,
                             input logic [255:0] nm, input logic [15:0] xlen);
        int data_n;
        put_le(sig, 4);
        put_le($urandom(), 2);          // version needed
        put_le(fl, 2);
        put_le(md, 2);
        put_le($urandom(), 4);          // mod time and date
        put_le($urandom(), 4);          // crc
        put_le(cs, 4);
        put_le(us, 4);
        put_le(nlen, 2);
        put_le(xlen, 2);
        for (int i = 0; i < nlen && i < BODY_CAP; i++)
            arc.push_back(i < MAX_NAME_BYTES ? nm[8*i +: 8] : 8'($urandom()));
        for (int i = 0; i < xlen && i < BODY_CAP; i++)
            arc.push_back(8'($urandom()));
        // huge sizes only appear in archives that get cut short
        data_n = (cs <= BODY_CAP) ? int'(cs) : 8;
        put_tail(data_n);
    endtask

    task automatic put_hit(input logic [15:0] fl, input logic [15:0] md,
                           input logic [31:0] cs, input logic [31:0] us,
                           input logic [15:0] xlen);
        put_entry(LFH_MAGIC, fl, md, cs, us, 16'(tgt_n), tgt, xlen);
    endtask

    // Near miss (one byte off) or a name of another length
    task automatic put_miss(input logic [15:0] fl, input logic [15:0] md,
                            input logic [31:0] cs, input logic [31:0] us,
                            input logic [15:0] xlen);
        logic [255:0] nm;
        int           len;
        int           k;
        nm  = tgt;
        len = tgt_n;
        if (tgt_n >= 1 && tgt_n <= MAX_NAME_BYTES && $urandom_range(0, 1)) begin
            k = $urandom_range(0, tgt_n - 1);
            nm[8*k +: 8] = nm[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end else begin
            nm  = rand_name();
            len = $urandom_range(0, 6);
            if (len == tgt_n)
                len = len + 1;
        end
        put_entry(LFH_MAGIC, fl, md, cs, us, 16'(len), nm, xlen);
    endtask

    // Hold the archive side until every owed result is out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoa);
        int gap;
        gap = tx_busy ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_archive_byte   <= b;
        i_end_of_archive <= eoa;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Stream the built archive; optionally hold after byte hold_at
    task automatic send_archive(input int hold_at);
        int last_ix;
        if (arc.size() == 0)
            arc.push_back(8'($urandom()));
        last_ix = arc.size() - 1;
        for (int i = 0; i <= last_ix; i++) begin
            send_byte(arc[i], i == last_ix);
            if (i == hold_at)
                drain();
        end
        arc.delete();
        archives_sent++;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
    endtask

    // New target, written only with the block idle between archives
    task automatic set_target(input logic [5:0] len, input logic [255:0] nm);
        logic [63:0] w;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        w      = {$urandom(), $urandom()};
        w[5:0] = len;
        cfg_write(CFG_NAME_LEN, w);
        cfg_write(CFG_NAME_WORD0, nm[63:0]);
        cfg_write(CFG_NAME_WORD1, nm[127:64]);
        cfg_write(CFG_NAME_WORD2, nm[191:128]);
        cfg_write(CFG_NAME_WORD3, nm[255:192]);
        // index past the last register must be ignored
        cfg_write(3'(CFG_NAME_WORD3 + $urandom_range(1, 3)), {$urandom(), $urandom()});
        i_cfg_valid <= 1'b0;
        tgt_n = len;
        tgt   = nm;
    endtask

    initial begin
        int          kind;
        int          cut;
        int          rand_base;
        logic [5:0]  len;
        logic [15:0] fl;
        logic [15:0] md;
        logic [31:0] cs;
        logic [31:0] us;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_archive_byte   = '0;
        i_end_of_archive = 1'b0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_NAME_LEN;
        i_cfg_data       = '0;
        tx_busy          = 1'b1;
        rx_busy          = 1'b1;
        tgt              = '0;
        tgt_n            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed cases, four-byte target ----
        set_target(6'd4, rand_name());
        put_hit(UTF8_FLAG, METHOD_STORED, 5, 5, 2);           // clean extract
        send_archive(-1);
        put_hit(FLAG_ENCRYPTED, METHOD_STORED, 3, 3, 0);      // bad flags
        send_archive(-1);
        put_hit(16'd0, METHOD_DEFLATE, 3, 3, 1);              // compressed
        send_archive(-1);
        put_hit(16'd0, METHOD_STORED, 3, 7, 0);               // size mismatch
        send_archive(-1);
        put_hit(16'h8001, METHOD_DEFLATE, 2, 9, 0);           // flags win over the rest
        send_archive(-1);
        // miss is skipped, hit follows, trailing bytes ignored; hold mid-archive
        put_miss(16'd0, METHOD_STORED, 4, 4, 3);
        put_hit(16'd0, METHOD_STORED, 2, 2, 0);
        put_tail(5);
        send_archive(40);
        // bad signature reports at once, rest ignored
        put_entry(LFH_MAGIC ^ 32'h0000_0100, 16'd0, METHOD_STORED, 2, 2, 16'(tgt_n), tgt, 0);
        put_tail(3);
        send_archive(-1);
        // truncated during payload
        put_hit(16'd0, METHOD_STORED, 20, 20, 0);
        repeat (6) void'(arc.pop_back());
        send_archive(-1);
        send_archive(-1);                                     // lone byte
        rx_busy = 1'b0;
        put_hit(16'd0, METHOD_STORED, 0, 0, 0);               // status on last name byte
        send_archive(-1);
        put_hit(UTF8_FLAG, METHOD_STORED, 0, 0, 3);           // status on last extra byte
        send_archive(-1);
        tx_busy = 1'b0;
        put_hit(16'd0, METHOD_STORED, 3, 3, 0);               // ok status on end byte
        send_archive(-1);
        put_miss(16'd0, METHOD_STORED, 2, 2, 0);              // nothing matches
        put_miss(UTF8_FLAG, METHOD_DEFLATE, 1, 5, 1);
        send_archive(-1);

        // ---- register extremes ----
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        set_target(6'd0, rand_name());
        put_hit(16'd0, METHOD_STORED, 0, 0, 0);               // status on last header byte
        put_tail(2);
        send_archive(-1);
        put_hit(UTF8_FLAG, METHOD_STORED, 2, 2, 1);
        send_archive(-1);
        set_target(6'd32, '1);
        put_miss(16'd0, METHOD_STORED, 1, 1, 0);
        put_hit(16'd0, METHOD_STORED, 1, 1, 0);
        send_archive(-1);
        set_target(6'd63, rand_name());                       // oversized, never matches
        put_hit(16'd0, METHOD_STORED, 2, 2, 0);
        send_archive(-1);

        // ---- random archives ----
        rand_base = archives_sent;
        while (bytes_sent < ITEM_TARGET ||
               archives_sent - rand_base < MIN_RANDOM_ARCHIVES) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 7))
                    0: len = 6'd0;
                    1: len = 6'd32;
                    2: len = 6'($urandom_range(33, 63));
                    default: len = 6'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 5))
                    0: set_target(len, '0);
                    1: set_target(len, '1);
                    default: set_target(len, rand_name());
                endcase
            end
            tx_busy = ($urandom_range(0, 2) != 0);
            rx_busy = ($urandom_range(0, 2) != 0);

            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // well-formed entries with random content
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 5) == 0)
                        fl = 16'($urandom());
                    else
                        fl = $urandom_range(0, 1) ? UTF8_FLAG : 16'd0;
                    md = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : METHOD_STORED;
                    cs = $urandom_range(0, 6);
                    us = ($urandom_range(0, 5) == 0) ? 32'($urandom_range(0, 6)) : cs;
                    if ($urandom_range(0, 1))
                        put_hit(fl, md, cs, us, 16'($urandom_range(0, 3)));
                    else
                        put_miss(fl, md, cs, us, 16'($urandom_range(0, 3)));
                end
                put_tail($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, arc.size());
                    while (arc.size() > cut)
                        void'(arc.pop_back());
                end
            end else if (kind == 7) begin
                put_entry(LFH_MAGIC ^ (32'd1 << $urandom_range(0, 31)), 16'd0,
                          METHOD_STORED, 2, 2, 16'(tgt_n), tgt, 0);
                put_tail($urandom_range(0, 4));
            end else if (kind == 8) begin
                put_tail($urandom_range(1, 40));
            end else begin
                // wild header fields, cut off somewhere
                put_entry(LFH_MAGIC, 16'($urandom()), 16'($urandom()), $urandom(),
                          $urandom(), 16'(tgt_n), tgt, 16'($urandom()));
                cut = $urandom_range(1, arc.size());
                while (arc.size() > cut)
                    void'(arc.pop_back());
            end
            send_archive(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : -1);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Streamed %0d archives (%0d bytes) across %0d register writes,",
                 archives_sent, bytes_sent, cfg_writes);
        $display("and checked %0d payload and status items against the prediction.",
                 checked_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
